// ===== src/sdas_pkg.sv =====
// Shared types and constants for the signed decimal add/subtract block.
package sdas_pkg;

  // Decimal arithmetic constants.
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  // Configuration port geometry and register map.
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;
  localparam logic        REG_SUBTRACT_OP = 1'b0;

  // One input transaction.
  typedef struct packed {
    logic       mode;
    logic [3:0] digit;
    logic       negative;
    logic       last_digit;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0] result_digit;
    logic       result_negative;
    logic       last;
    logic       overflow;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CALC,
    ST_DRAIN,
    ST_FINISH,
    ST_EMIT_RD,
    ST_EMIT_LD
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc_init;
    logic issue;
    logic finish;
    logic emit_rd;
    logic emit_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;
    logic out_free;
    logic rd_last;
  } dp_status_t;

endpackage

// ===== src/sdas_ctrl.sv =====
// Sequencer for loading, the digit-serial pass and result emission.
module sdas_ctrl
  import sdas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  in_item_t   in_data,
  output logic       in_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && in_data.mode && in_data.last_digit) begin
          cmd.calc_init = 1'b1;
          state_next    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.issue = 1'b1;
        if (status.pos_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        if (status.out_free) begin
          cmd.emit_rd = 1'b1;
          state_next  = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        state_next    = status.rd_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== src/sdas_datapath.sv =====
// Operand memories, digit-serial add/subtract unit, result memory and output register.
module sdas_datapath
  import sdas_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  logic       subtract_op,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned LW = $clog2(MAX_DIGITS + 1);
  localparam logic [AW-1:0] POS_LAST  = AW'(MAX_DIGITS - 1);
  localparam logic [LW-1:0] LEN_FULL  = LW'(MAX_DIGITS);
  localparam logic [LW-1:0] TOP_CARRY = LW'(MAX_DIGITS);

  // Operand stores, most significant digit at index zero.
  logic [3:0] first_mem  [MAX_DIGITS];
  logic [3:0] second_mem [MAX_DIGITS];
  // Result store: low nibble holds the sum or first minus second,
  // high nibble holds second minus first.
  logic [7:0] sum_mem    [MAX_DIGITS + 1];

  logic [LW-1:0] first_len;
  logic [LW-1:0] second_len;
  logic          first_sign;
  logic          second_sign;
  logic          ovf_seen;

  logic [3:0] digit_sat;
  logic       esign;
  logic       like;

  // Incoming digits saturate at nine.
  assign digit_sat = (in_data.digit > DIGIT_MAX) ? DIGIT_MAX : in_data.digit;
  assign esign     = second_sign ^ subtract_op;
  assign like      = (first_sign == esign);

  // Operand length, sign and overflow tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_len   <= '0;
      second_len  <= '0;
      first_sign  <= 1'b0;
      second_sign <= 1'b0;
      ovf_seen    <= 1'b0;
    end else if (cmd.finish) begin
      first_len   <= '0;
      second_len  <= '0;
      first_sign  <= 1'b0;
      second_sign <= 1'b0;
      ovf_seen    <= 1'b0;
    end else if (cmd.load) begin
      if (!in_data.mode) begin
        if (first_len == '0) begin
          first_sign <= in_data.negative;
        end
        if (first_len < LEN_FULL) begin
          first_len <= first_len + LW'(1);
        end else begin
          ovf_seen <= 1'b1;
        end
      end else begin
        if (second_len == '0) begin
          second_sign <= in_data.negative;
        end
        if (second_len < LEN_FULL) begin
          second_len <= second_len + LW'(1);
        end else begin
          ovf_seen <= 1'b1;
        end
      end
    end
  end

  // Operand store writes.
  always_ff @(posedge clk) begin
    if (cmd.load && !in_data.mode && (first_len < LEN_FULL)) begin
      first_mem[first_len[AW-1:0]] <= digit_sat;
    end
    if (cmd.load && in_data.mode && (second_len < LEN_FULL)) begin
      second_mem[second_len[AW-1:0]] <= digit_sat;
    end
  end

  // Position counter, least significant position first.
  logic [AW-1:0] pos;
  logic [LW-1:0] idx_a;
  logic [LW-1:0] idx_b;
  logic          a_in;
  logic          b_in;

  always_ff @(posedge clk) begin
    if (cmd.calc_init) begin
      pos <= '0;
    end else if (cmd.issue) begin
      pos <= pos + AW'(1);
    end
  end

  assign status.pos_last = (pos == POS_LAST);
  assign idx_a = first_len - LW'(pos) - LW'(1);
  assign idx_b = second_len - LW'(pos) - LW'(1);
  assign a_in  = LW'(pos) < first_len;
  assign b_in  = LW'(pos) < second_len;

  // Registered operand reads, one position a cycle.
  logic [3:0]    a_rd;
  logic [3:0]    b_rd;
  logic          a_ok;
  logic          b_ok;
  logic [AW-1:0] proc_pos;
  logic          proc_valid;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      a_rd     <= first_mem[idx_a[AW-1:0]];
      b_rd     <= second_mem[idx_b[AW-1:0]];
      a_ok     <= a_in;
      b_ok     <= b_in;
      proc_pos <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= cmd.issue;
    end
  end

  // One decimal position: sum with carry and both differences with borrow.
  logic [3:0] a_val;
  logic [3:0] b_val;
  logic [4:0] sum5;
  logic [4:0] diff_ab5;
  logic [4:0] diff_ba5;
  logic       carry_next;
  logic [3:0] sum_dig;
  logic [3:0] dig_ab;
  logic [3:0] dig_ba;
  logic [3:0] lane0;
  logic [3:0] lane1;

  logic       carry;
  logic       borrow_ab;
  logic       borrow_ba;
  logic       first_big;
  logic [LW-1:0] top0;
  logic [LW-1:0] top1;
  logic       nz0;
  logic       nz1;

  assign a_val      = a_ok ? a_rd : 4'd0;
  assign b_val      = b_ok ? b_rd : 4'd0;
  assign sum5       = {1'b0, a_val} + {1'b0, b_val} + {4'd0, carry};
  assign carry_next = (sum5 >= RADIX);
  assign sum_dig    = carry_next ? 4'(sum5 - RADIX) : sum5[3:0];
  assign diff_ab5   = {1'b0, a_val} - {1'b0, b_val} - {4'd0, borrow_ab};
  assign diff_ba5   = {1'b0, b_val} - {1'b0, a_val} - {4'd0, borrow_ba};
  assign dig_ab     = diff_ab5[4] ? 4'(diff_ab5 + RADIX) : diff_ab5[3:0];
  assign dig_ba     = diff_ba5[4] ? 4'(diff_ba5 + RADIX) : diff_ba5[3:0];
  assign lane0      = like ? sum_dig : dig_ab;
  assign lane1      = dig_ba;

  // Carries, magnitude compare and highest nonzero digit of each lane.
  always_ff @(posedge clk) begin
    if (cmd.calc_init) begin
      carry     <= 1'b0;
      borrow_ab <= 1'b0;
      borrow_ba <= 1'b0;
      first_big <= 1'b1;
      top0      <= '0;
      top1      <= '0;
      nz0       <= 1'b0;
      nz1       <= 1'b0;
    end else if (proc_valid) begin
      carry     <= carry_next;
      borrow_ab <= diff_ab5[4];
      borrow_ba <= diff_ba5[4];
      // Higher positions are seen later, so they override the compare.
      if (a_val != b_val) begin
        first_big <= (a_val > b_val);
      end
      if (lane0 != 4'd0) begin
        top0 <= LW'(proc_pos);
        nz0  <= 1'b1;
      end
      if (lane1 != 4'd0) begin
        top1 <= LW'(proc_pos);
        nz1  <= 1'b1;
      end
    end
  end

  // Result selection at the end of the pass.
  logic          use_ba;
  logic          carry_top;
  logic [LW-1:0] fin_top;
  logic          fin_nz;
  logic          fin_neg;

  assign use_ba    = !like && !first_big;
  assign carry_top = like && carry;
  assign fin_top   = use_ba ? top1 : (carry_top ? TOP_CARRY : top0);
  assign fin_nz    = use_ba ? nz1 : (nz0 || carry_top);
  assign fin_neg   = fin_nz && (like ? first_sign : (first_big ? first_sign : esign));

  // Result store writes: one per position, then the final carry.
  always_ff @(posedge clk) begin
    if (proc_valid) begin
      sum_mem[LW'(proc_pos)] <= {lane1, lane0};
    end else if (cmd.finish) begin
      sum_mem[TOP_CARRY] <= {4'd0, 3'd0, carry_top};
    end
  end

  // Result snapshot and emission counter.
  logic          res_lane_ba;
  logic          res_neg;
  logic          res_ovf;
  logic [LW-1:0] emit_pos;
  logic [7:0]    rd_word;
  logic          rd_last;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_lane_ba <= use_ba;
      res_neg     <= fin_neg;
      res_ovf     <= ovf_seen;
      emit_pos    <= fin_top;
    end else if (cmd.emit_rd) begin
      rd_word <= sum_mem[emit_pos];
      rd_last <= (emit_pos == '0);
      if (emit_pos != '0) begin
        emit_pos <= emit_pos - LW'(1);
      end
    end
  end

  assign status.rd_last  = rd_last;
  assign status.out_free = !out_valid || !out_stall;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data.result_digit    <= res_lane_ba ? rd_word[7:4] : rd_word[3:0];
      out_data.result_negative <= res_neg;
      out_data.last            <= rd_last;
      out_data.overflow        <= res_ovf;
    end
  end

endmodule

// ===== src/signed_decimal_add_subtract.sv =====
// Signed-magnitude decimal adder/subtracter. Operands arrive one digit per transaction, most
// significant digit first, and are accepted at one digit per cycle while the block is loading;
// digits past MAX_DIGITS are dropped and flag overflow on every result digit. The transaction
// that carries the second operand's final digit starts the computation: one pass walks the operand
// memories least significant position first through their single read port, forming the sum or
// both differences and the magnitude compare at once. Result digits then leave most significant
// first with leading zeros suppressed, each read from the result memory port and then loaded into
// the output register; a digit is read only while that register is free or being emptied.
// Input stays stalled from the start of the pass until the final result digit sits in the output
// register. The operation (add or subtract) is set by subtract_op at address 0.
module signed_decimal_add_subtract
  import sdas_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic       subtract_op;
  logic       reg_hit;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_SUBTRACT_OP);

  always_ff @(posedge clk) begin
    if (rst) begin
      subtract_op <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      subtract_op <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {{(PDATA_W - 1){1'b0}}, subtract_op} : '0;

  // Sequencer.
  sdas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath.
  sdas_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .subtract_op (subtract_op),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // The output register is always empty when a result digit is loaded into it.
  assert property (@(posedge clk) disable iff (rst) cmd.emit_load |-> !out_valid)
    else $error("result digit loaded over a pending transaction");

  // No input transaction is taken while the digit pass runs.
  assert property (@(posedge clk) disable iff (rst) (cmd.issue || cmd.finish) |-> in_stall)
    else $error("input accepted during computation");

  // Load, issue, finish and emit commands come from distinct phases and never overlap.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.issue, cmd.finish, cmd.emit_rd, cmd.emit_load}))
    else $error("overlapping datapath commands");

endmodule

// ===== tb/sv/decimal_result_checker.sv =====
// Checker that predicts every result digit of the decimal add/subtract block and compares it.
`timescale 1ns / 100ps
module decimal_result_checker
  import sdas_pkg::*;
#(
  parameter int unsigned DIGIT_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  localparam logic [PADDR_W-1:0] OP_ADDR = PADDR_W'(4 * int'(REG_SUBTRACT_OP));

  // Shadow copy of the operand stores, lengths, signs and the operation.
  logic [3:0]  lhs_mem [DIGIT_SLOTS];
  logic [3:0]  rhs_mem [DIGIT_SLOTS];
  int unsigned lhs_len;
  int unsigned rhs_len;
  logic        lhs_neg;
  logic        rhs_neg;
  logic        too_long;
  logic        sub_mode;

  // Result digits predicted but not yet seen on the output channel.
  out_item_t result_digits_due [$];

  // Digit of an operand at a given weight, zero above its length.
  function automatic logic [3:0] lhs_at(int unsigned pos);
    return (pos < lhs_len) ? lhs_mem[lhs_len - 1 - pos] : 4'd0;
  endfunction

  function automatic logic [3:0] rhs_at(int unsigned pos);
    return (pos < rhs_len) ? rhs_mem[rhs_len - 1 - pos] : 4'd0;
  endfunction

  // Works out the signed sum or difference and queues its digits, top digit first.
  function automatic void finish_pair();
    logic [3:0]  sum [DIGIT_SLOTS + 1];
    logic        eff_neg;
    logic        res_neg;
    logic        lhs_big;
    int unsigned carry;
    int unsigned total;
    int unsigned big;
    int unsigned take;
    int unsigned top;
    int unsigned pos;
    int          p;
    out_item_t   item;
    eff_neg = rhs_neg ^ sub_mode;
    if (lhs_neg == eff_neg) begin
      // Like signs: add the magnitudes with a decimal carry.
      carry = 0;
      for (pos = 0; pos < DIGIT_SLOTS; pos++) begin
        total = lhs_at(pos) + rhs_at(pos) + carry;
        carry = (total >= 10) ? 1 : 0;
        sum[pos] = 4'(total - 10 * carry);
      end
      sum[DIGIT_SLOTS] = 4'(carry);
      res_neg = lhs_neg;
    end else begin
      // Unlike signs: find the larger magnitude, then subtract with borrow.
      lhs_big = 1'b1;
      for (p = DIGIT_SLOTS - 1; p >= 0; p--) begin
        if (lhs_at(p) != rhs_at(p)) begin
          lhs_big = lhs_at(p) > rhs_at(p);
          break;
        end
      end
      carry = 0;
      for (pos = 0; pos < DIGIT_SLOTS; pos++) begin
        big  = lhs_big ? lhs_at(pos) : rhs_at(pos);
        take = (lhs_big ? rhs_at(pos) : lhs_at(pos)) + carry;
        if (big < take) begin
          sum[pos] = 4'(big + 10 - take);
          carry = 1;
        end else begin
          sum[pos] = 4'(big - take);
          carry = 0;
        end
      end
      sum[DIGIT_SLOTS] = 4'd0;
      res_neg = lhs_big ? lhs_neg : eff_neg;
    end

    // Leading zeros are suppressed, but at least one digit goes out; zero is positive.
    top = 0;
    for (p = DIGIT_SLOTS; p >= 0; p--) begin
      if (sum[p] != 4'd0) begin
        top = p;
        break;
      end
    end
    if (top == 0 && sum[0] == 4'd0) res_neg = 1'b0;
    for (p = top; p >= 0; p--) begin
      item.result_digit    = sum[p];
      item.result_negative = res_neg;
      item.last            = (p == 0);
      item.overflow        = too_long;
      result_digits_due.push_back(item);
    end

    // The block clears the operands for the next pair.
    lhs_len  = 0;
    rhs_len  = 0;
    lhs_neg  = 1'b0;
    rhs_neg  = 1'b0;
    too_long = 1'b0;
  endfunction

  // Appends one accepted digit to its operand; the second operand's final digit computes.
  function automatic void absorb_digit(in_item_t it);
    logic [3:0] d;
    d = (it.digit > DIGIT_MAX) ? DIGIT_MAX : it.digit;
    if (!it.mode) begin
      if (lhs_len == 0) lhs_neg = it.negative;
      if (lhs_len < DIGIT_SLOTS) begin
        lhs_mem[lhs_len] = d;
        lhs_len++;
      end else begin
        too_long = 1'b1;
      end
    end else begin
      if (rhs_len == 0) rhs_neg = it.negative;
      if (rhs_len < DIGIT_SLOTS) begin
        rhs_mem[rhs_len] = d;
        rhs_len++;
      end else begin
        too_long = 1'b1;
      end
      if (it.last_digit) finish_pair();
    end
  endfunction

  function automatic void check_field(string field, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      lhs_len  = 0;
      rhs_len  = 0;
      lhs_neg  = 1'b0;
      rhs_neg  = 1'b0;
      too_long = 1'b0;
      sub_mode = 1'b0;
      result_digits_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_digits_due.size() == 0) begin
          $error("result_digit: expected none, got %0d", out_data.result_digit);
          fail_count++;
        end else begin
          want = result_digits_due.pop_front();
          check_field("result_digit", want.result_digit, out_data.result_digit);
          check_field("result_negative", want.result_negative, out_data.result_negative);
          check_field("last", want.last, out_data.last);
          check_field("overflow", want.overflow, out_data.overflow);
        end
      end
      if (psel && penable && pwrite && pready && paddr == OP_ADDR) sub_mode = pwdata[0];
      if (in_valid && !in_stall) absorb_digit(in_data);
    end
    pending <= result_digits_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: clock, reset, operand and register stimulus, and the final verdict.
`timescale 1ns / 100ps
module tb;
  import sdas_pkg::*;

  localparam int unsigned DIGITS      = 32;
  localparam int unsigned ITEM_TARGET = 205;
  localparam int unsigned TAIL_START  = ITEM_TARGET - 40;

  localparam logic [PADDR_W-1:0] OP_ADDR = PADDR_W'(4 * int'(REG_SUBTRACT_OP));
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SUB    = 1'b1;
  localparam logic FIRST_OP  = 1'b0;
  localparam logic SECOND_OP = 1'b1;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent       = 0;
  int unsigned stall_left = 0;
  bit          quiet      = 1'b0;
  logic        subtract_now = OP_ADD;

  signed_decimal_add_subtract #(
    .MAX_DIGITS(DIGITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  decimal_result_checker #(
    .DIGIT_SLOTS(DIGITS)
  ) result_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run must end well before this even with the slowest legal handshakes.
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Output backpressure comes in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t digit_item(logic mode, logic [3:0] value, logic neg, logic fin);
    in_item_t it;
    it.mode       = mode;
    it.digit      = value;
    it.negative   = neg;
    it.last_digit = fin;
    return it;
  endfunction

  // Mostly decimal digits, sometimes a code above nine.
  function automatic logic [3:0] pick_digit();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
  endfunction

  // Offers one input transaction, after an optional gap, and holds it until accepted.
  task automatic feed(input in_item_t it);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Stops sending and waits until every predicted result digit has been seen.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic set_op(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OP_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    subtract_now = value;
  endtask

  // Sends one operand pair with random content; the second operand's final digit goes last.
  task automatic send_pair(input int unsigned lhs_count, input int unsigned rhs_count,
                           input bit all_nines);
    in_item_t    lhs_q [$];
    in_item_t    rhs_q [$];
    logic        lhs_sign;
    logic        rhs_sign;
    bit          mirror;
    bit          mix;
    int unsigned i;
    lhs_sign = 1'($urandom_range(0, 1));
    // Matching effective signs make the nines add into the widest possible sum.
    rhs_sign = all_nines ? (lhs_sign ^ subtract_now) : 1'($urandom_range(0, 1));
    mirror   = (lhs_count == rhs_count) && ($urandom_range(0, 1) == 0);
    mix      = ($urandom_range(0, 4) == 0);
    for (i = 0; i < lhs_count; i++)
      lhs_q.push_back(digit_item(FIRST_OP, all_nines ? DIGIT_MAX : pick_digit(),
                                 (i == 0) ? lhs_sign : 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1))));
    for (i = 0; i < rhs_count; i++)
      rhs_q.push_back(digit_item(SECOND_OP,
                                 all_nines ? DIGIT_MAX : (mirror ? lhs_q[i].digit : pick_digit()),
                                 (i == 0) ? rhs_sign : 1'($urandom_range(0, 1)),
                                 i == rhs_count - 1));
    // Optionally interleave the two operands.
    while (lhs_q.size() != 0 || rhs_q.size() != 0) begin
      if (lhs_q.size() != 0 && (!mix || rhs_q.size() == 1 || $urandom_range(0, 1) == 0))
        feed(lhs_q.pop_front());
      else
        feed(rhs_q.pop_front());
    end
  endtask

  initial begin
    int unsigned pair_no;
    int unsigned lhs_count;
    int unsigned rhs_count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases with addition.
    set_op(OP_ADD);
    // An empty first operand counts as plus zero.
    feed(digit_item(SECOND_OP, 4'd5, 1'b1, 1'b1));
    // A digit code above nine saturates; -9 + 9 must give a positive zero.
    feed(digit_item(FIRST_OP, 4'd15, 1'b1, 1'b0));
    feed(digit_item(SECOND_OP, 4'd12, 1'b0, 1'b1));
    // Leading zeros do not make an operand larger: 007 + (-12).
    feed(digit_item(FIRST_OP, 4'd0, 1'b0, 1'b0));
    feed(digit_item(FIRST_OP, 4'd0, 1'b1, 1'b0));
    feed(digit_item(FIRST_OP, 4'd7, 1'b1, 1'b0));
    feed(digit_item(SECOND_OP, 4'd1, 1'b1, 1'b0));
    feed(digit_item(SECOND_OP, 4'd2, 1'b0, 1'b1));
    // Interleaved operands each keep their own digits: 13 + 24.
    feed(digit_item(FIRST_OP, 4'd1, 1'b0, 1'b0));
    feed(digit_item(SECOND_OP, 4'd2, 1'b0, 1'b0));
    feed(digit_item(FIRST_OP, 4'd3, 1'b0, 1'b0));
    feed(digit_item(SECOND_OP, 4'd4, 1'b0, 1'b1));
    // A final mark on a first operand digit changes nothing: 56 + 1.
    feed(digit_item(FIRST_OP, 4'd5, 1'b0, 1'b1));
    feed(digit_item(FIRST_OP, 4'd6, 1'b0, 1'b0));
    feed(digit_item(SECOND_OP, 4'd1, 1'b0, 1'b1));

    // Directed cases with subtraction.
    wait_idle();
    set_op(OP_SUB);
    // Smaller minus larger flips the sign: 3 - 8.
    feed(digit_item(FIRST_OP, 4'd3, 1'b0, 1'b0));
    feed(digit_item(SECOND_OP, 4'd8, 1'b0, 1'b1));
    // The borrow ripples through every upper digit: 1000 - 1.
    feed(digit_item(FIRST_OP, 4'd1, 1'b0, 1'b0));
    feed(digit_item(FIRST_OP, 4'd0, 1'b0, 1'b0));
    feed(digit_item(FIRST_OP, 4'd0, 1'b0, 1'b0));
    feed(digit_item(FIRST_OP, 4'd0, 1'b0, 1'b0));
    feed(digit_item(SECOND_OP, 4'd1, 1'b0, 1'b1));
    // Subtracting a positive from a negative adds with carry: -999 - 1.
    feed(digit_item(FIRST_OP, 4'd9, 1'b1, 1'b0));
    feed(digit_item(FIRST_OP, 4'd9, 1'b0, 1'b0));
    feed(digit_item(FIRST_OP, 4'd9, 1'b1, 1'b0));
    feed(digit_item(SECOND_OP, 4'd1, 1'b0, 1'b1));

    // Random operand pairs, with the operation changed now and then while idle.
    pair_no = 0;
    while (sent < ITEM_TARGET) begin
      if (pair_no % 4 == 3) begin
        wait_idle();
        set_op(1'($urandom_range(0, 1)));
      end
      quiet = (sent >= TAIL_START) || ($urandom_range(0, 3) == 0);
      case (pair_no)
        2: begin
          // Overlong first operand of nines plus 32 nines: the widest result, flagged.
          send_pair(DIGITS + 2, DIGITS, 1'b1);
        end
        6: begin
          // Overlong second operand.
          send_pair(1, DIGITS + 1, 1'b0);
        end
        default: begin
          lhs_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
          if ($urandom_range(0, 11) == 0) lhs_count = $urandom_range(7, 20);
          rhs_count = ($urandom_range(0, 2) == 0 && lhs_count != 0) ?
                      lhs_count : $urandom_range(1, 6);
          send_pair(lhs_count, rhs_count, 1'b0);
        end
      endcase
      pair_no++;
    end

    // Let every result drain, then give the verdict.
    quiet = 1'b1;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DIGITS + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
